FILE: rtl/css_pkg.sv
package css_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int CMD_W = 2;
    localparam int VAL_W = 32;
    localparam int POS_W = 4;
    localparam int CNT_W = 5;
    localparam int CAP_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SEARCH = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic signed [VAL_W-1:0] element_value;
    } t_in_item;

    typedef struct packed {
        logic             ok;
        logic [POS_W-1:0] position;
        logic [CNT_W-1:0] count;
        logic             full_res;
        logic             empty_res;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic add;
        logic walk;
        logic shift;
        logic found;
        logic dec;
    } t_dp_ctrl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             can_add;
        logic             hit;
        logic             ptr_end;
        logic             lag_vld;
    } t_dp_stat;

endpackage

FILE: rtl/compacting_set_store_unit.sv
// Bounded store of signed 32-bit values packed from index 0, with add, remove
// (first match, later entries compacted down) and search. A command is taken
// when start is high and busy is low; its single result appears on o_result
// for exactly one cycle with o_done high and must be captured then, as the
// block cannot be held off. A search or remove walks the entries through the
// single read port of the store, one entry per cycle. The capacity register
// is written through the cfg channel, which is ready whenever busy is low;
// the effective capacity is the lesser of it and the store depth.
module compacting_set_store_unit
    import css_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  t_in_item         i_item,
    output logic             busy,
    output logic             o_done,
    output t_result          o_result,
    input  logic             i_cfg_valid,
    input  logic [CAP_W-1:0] i_cfg_data,
    output logic             o_cfg_ready
);

    t_dp_ctrl dp_ctrl;
    t_dp_stat dp_stat;
    logic     cfg_we;

    assign o_cfg_ready = ~busy;
    assign cfg_we      = i_cfg_valid & o_cfg_ready;

    css_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_ctrl  (dp_ctrl),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    css_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_ctrl     (dp_ctrl),
        .o_stat     (dp_stat),
        .o_result   (o_result)
    );

endmodule

FILE: rtl/css_dpath.sv
module css_dpath
    import css_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_in_item         i_item,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_data,
    input  t_dp_ctrl         i_ctrl,
    output t_dp_stat         o_stat,
    output t_result          o_result
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = (CW > CAP_W) ? CW : CAP_W;
    localparam int PW = (AW > POS_W) ? AW : POS_W;

    logic signed [VAL_W-1:0] mem [DEPTH];
    logic signed [VAL_W-1:0] r_rdata;
    logic signed [VAL_W-1:0] r_value;
    logic [CMD_W-1:0]        r_cmd;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic [CW-1:0]           r_ptr;
    logic [CW-1:0]           r_lag;
    logic                    r_lag_vld;
    logic                    r_ok;
    logic [AW-1:0]           r_pos;
    logic [CAP_W-1:0]        r_cap;

    logic [MW-1:0]           count_ext;
    logic [MW-1:0]           cap_ext;
    logic [MW-1:0]           depth_ext;
    logic [PW-1:0]           pos_ext;
    logic [CW-1:0]           lag_m1;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic signed [VAL_W-1:0] mem_wdata;
    logic                    ptr_end;
    logic                    hit;

    assign count_ext = MW'(r_count);
    assign cap_ext   = MW'(r_cap);
    assign depth_ext = MW'(DEPTH);
    assign pos_ext   = PW'(r_pos);
    assign lag_m1    = r_lag - CW'(1);
    assign ptr_end   = (r_ptr >= r_count);
    assign hit       = r_lag_vld && (r_rdata == r_value);

    // During compaction the entry read last cycle moves down one place.
    assign mem_we    = i_ctrl.add || (i_ctrl.shift && r_lag_vld);
    assign mem_waddr = i_ctrl.add ? r_count[AW-1:0] : lag_m1[AW-1:0];
    assign mem_wdata = i_ctrl.add ? r_value : r_rdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[r_ptr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_value <= i_item.element_value;
            r_cmd   <= i_item.command;
        end
    end

    always_comb begin
        n_count = r_count;
        priority if (i_ctrl.add) begin
            n_count = r_count + CW'(1);
        end else if (i_ctrl.dec) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_cap     <= CAP_RESET;
            r_ptr     <= '0;
            r_lag     <= '0;
            r_lag_vld <= 1'b0;
            r_ok      <= 1'b0;
            r_pos     <= '0;
        end else begin
            r_count <= n_count;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (i_ctrl.load) begin
                r_ptr     <= '0;
                r_lag_vld <= 1'b0;
                r_ok      <= 1'b0;
                r_pos     <= '0;
            end else begin
                if (i_ctrl.walk) begin
                    if (!ptr_end) begin
                        r_ptr     <= r_ptr + CW'(1);
                        r_lag     <= r_ptr;
                        r_lag_vld <= 1'b1;
                    end else begin
                        r_lag_vld <= 1'b0;
                    end
                end
                if (i_ctrl.add) begin
                    r_ok  <= 1'b1;
                    r_pos <= r_count[AW-1:0];
                end else if (i_ctrl.found) begin
                    r_ok  <= 1'b1;
                    r_pos <= r_lag[AW-1:0];
                end
            end
        end
    end

    assign o_stat.cmd     = r_cmd;
    assign o_stat.can_add = (count_ext < cap_ext) && (count_ext < depth_ext);
    assign o_stat.hit     = hit;
    assign o_stat.ptr_end = ptr_end;
    assign o_stat.lag_vld = r_lag_vld;

    assign o_result.ok        = r_ok;
    assign o_result.position  = pos_ext[POS_W-1:0];
    assign o_result.count     = count_ext[CNT_W-1:0];
    assign o_result.full_res  = (count_ext >= cap_ext) || (count_ext >= depth_ext);
    assign o_result.empty_res = (r_count == '0);

endmodule

FILE: rtl/css_ctrl.sv
module css_ctrl
    import css_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_ctrl o_ctrl,
    output logic     o_busy,
    output logic     o_done
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (i_stat.cmd)
                    CMD_REMOVE,
                    CMD_SEARCH: n_state = ST_SCAN;
                    default:    n_state = ST_DONE;
                endcase
            end
            ST_SCAN: begin
                priority if (i_stat.hit) begin
                    n_state = (i_stat.cmd == CMD_REMOVE) ? ST_SHIFT : ST_DONE;
                end else if (i_stat.ptr_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_SHIFT: begin
                if (i_stat.ptr_end && !i_stat.lag_vld) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_ctrl.load = i_start;
            end
            ST_DECODE: begin
                o_ctrl.add = (i_stat.cmd == CMD_ADD) && i_stat.can_add;
            end
            ST_SCAN: begin
                // The read of the entry after a hit is issued here, so
                // compaction starts with its data already on hand.
                o_ctrl.walk  = 1'b1;
                o_ctrl.found = i_stat.hit;
            end
            ST_SHIFT: begin
                o_ctrl.walk  = 1'b1;
                o_ctrl.shift = 1'b1;
                o_ctrl.dec   = i_stat.ptr_end && !i_stat.lag_vld;
            end
            ST_DONE: begin
                o_ctrl = '0;
            end
            default: begin
                o_ctrl = '0;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = (r_state == ST_DONE);

endmodule

FILE: rtl/css_checker.sv
module css_checker
    import css_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_done,
    input t_result          o_result
);

    // A result beat belongs to a command still in flight.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result beat without a command in flight");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("more than one result beat for a command");

    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> $past(o_done))
        else $error("busy dropped without a result beat");

    a_fail_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.ok) |-> (o_result.position == '0))
        else $error("failed command reported a non-zero position");

endmodule

bind compacting_set_store_unit css_checker u_css_checker (.*);
